// ===== rtl/chsw_pkg.sv =====
// Shared types and constants of the chunk header stream walker.
`default_nettype none

package chsw_pkg;

    localparam int HEADER_BYTES = 12;
    localparam logic [3:0] HDR_LAST_IDX = 4'(HEADER_BYTES - 1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_TOO_SMALL = 2'd0;
    localparam logic [1:0] ERR_TRUNC_HDR = 2'd1;
    localparam logic [1:0] ERR_OVERRUN   = 2'd2;

    localparam logic [1:0] MODE_ALL  = 2'd0;
    localparam logic [1:0] MODE_ROOT = 2'd1;
    localparam logic [1:0] MODE_FIND = 2'd2;

    localparam logic [1:0] CFG_REGION_SIZE = 2'd0;
    localparam logic [1:0] CFG_WALK_MODE   = 2'd1;
    localparam logic [1:0] CFG_MATCH_TYPE  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] chunk_type;
        logic [31:0] payload_size;
        logic [31:0] format_version;
        logic [31:0] payload_offset;
        logic [1:0]  error_code;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic      two;
        t_out_item res_a;
        t_out_item res_b;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/chsw_front.sv =====
// Front part: walks the byte stream and classifies each item into its results.
`default_nettype none

module chsw_front
    import chsw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire t_in_item    i_item,
    input  wire logic [31:0] i_region_size,
    input  wire logic [1:0]  i_walk_mode,
    input  wire logic [31:0] i_match_type,
    output logic             o_q_push,
    output t_entry           o_q_entry
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_position, n_position;
    logic [3:0]  r_hdr_idx, n_hdr_idx;
    logic [31:0] r_type, n_type;
    logic [31:0] r_size, n_size;
    logic [31:0] r_version, n_version;
    logic [31:0] r_left, n_left;

    logic [31:0] pos_inc;
    logic [31:0] bnd_pos;
    logic        bnd_end;
    logic        bnd_short;
    logic        overrun;
    logic        hit;
    logic [31:0] byte_sh;
    logic [31:0] ver_merged;
    logic [1:0]  cnt;
    logic        run_bnd;
    t_out_item   res_v [2];
    t_out_item   res_end;
    t_out_item   rec;

    function automatic t_out_item f_error(input logic [1:0] code);
        t_out_item r;
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    assign pos_inc    = r_position + 32'd1;
    assign bnd_pos    = (i_item.op == OP_START) ? 32'd0 : pos_inc;
    assign bnd_end    = bnd_pos >= i_region_size;
    assign bnd_short  = ({1'b0, bnd_pos} + 33'(HEADER_BYTES)) > {1'b0, i_region_size};
    assign overrun    = ({1'b0, pos_inc} + {1'b0, r_size}) > {1'b0, i_region_size};
    assign hit        = (i_walk_mode != MODE_FIND) || (r_type == i_match_type);
    assign byte_sh    = {24'd0, i_item.data_byte} << {r_hdr_idx[1:0], 3'b000};
    assign ver_merged = r_version | byte_sh;

    always_comb begin
        res_end = '0;
        res_end.kind = KIND_END;
        rec = '0;
        rec.kind = KIND_RECORD;
        rec.chunk_type = r_type;
        rec.payload_size = r_size;
        rec.format_version = ver_merged;
        rec.payload_offset = pos_inc;
    end

    always_comb begin
        n_phase    = r_phase;
        n_position = r_position;
        n_hdr_idx  = r_hdr_idx;
        n_type     = r_type;
        n_size     = r_size;
        n_version  = r_version;
        n_left     = r_left;
        res_v[0]   = '0;
        res_v[1]   = '0;
        cnt        = 2'd0;
        run_bnd    = 1'b0;
        if (i_accept) begin
            if (i_item.op == OP_START) begin
                n_position = '0;
                n_left     = '0;
                n_phase    = PH_HEADER;
                n_hdr_idx  = '0;
                n_type     = '0;
                n_size     = '0;
                n_version  = '0;
                if (i_walk_mode == MODE_ROOT) begin
                    if (i_region_size < 32'(HEADER_BYTES)) begin
                        n_phase  = PH_DONE;
                        res_v[0] = f_error(ERR_TOO_SMALL);
                        cnt      = 2'd1;
                    end
                end else begin
                    run_bnd = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        n_position = pos_inc;
                        n_hdr_idx  = r_hdr_idx + 4'd1;
                        unique case (r_hdr_idx[3:2])
                            2'b00:   n_type    = r_type | byte_sh;
                            2'b01:   n_size    = r_size | byte_sh;
                            default: n_version = ver_merged;
                        endcase
                        if (r_hdr_idx == HDR_LAST_IDX) begin
                            if (overrun) begin
                                n_phase  = PH_DONE;
                                res_v[0] = (i_walk_mode == MODE_FIND) ? res_end
                                                                      : f_error(ERR_OVERRUN);
                                cnt      = 2'd1;
                            end else begin
                                if (hit) begin
                                    res_v[0] = rec;
                                    cnt      = 2'd1;
                                end
                                if (i_walk_mode == MODE_ROOT ||
                                    (i_walk_mode == MODE_FIND && hit)) begin
                                    n_phase         = PH_DONE;
                                    res_v[cnt[0]]   = res_end;
                                    cnt             = cnt + 2'd1;
                                end else begin
                                    n_left = r_size;
                                    if (r_size == 32'd0) begin
                                        run_bnd = 1'b1;
                                    end else begin
                                        n_phase = PH_PAYLOAD;
                                    end
                                end
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        n_position = pos_inc;
                        n_left     = r_left - 32'd1;
                        if (r_left == 32'd1) begin
                            run_bnd = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (run_bnd) begin
                if (bnd_end) begin
                    n_phase       = PH_DONE;
                    res_v[cnt[0]] = res_end;
                    cnt           = cnt + 2'd1;
                end else if (bnd_short) begin
                    n_phase       = PH_DONE;
                    res_v[cnt[0]] = (i_walk_mode == MODE_FIND) ? res_end
                                                               : f_error(ERR_TRUNC_HDR);
                    cnt           = cnt + 2'd1;
                end else begin
                    n_phase   = PH_HEADER;
                    n_hdr_idx = '0;
                    n_type    = '0;
                    n_size    = '0;
                    n_version = '0;
                end
            end
        end
    end

    assign o_q_push        = cnt != 2'd0;
    assign o_q_entry.two   = cnt[1];
    assign o_q_entry.res_a = res_v[0];
    assign o_q_entry.res_b = res_v[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_position <= '0;
            r_hdr_idx  <= '0;
            r_type     <= '0;
            r_size     <= '0;
            r_version  <= '0;
            r_left     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_position <= n_position;
            r_hdr_idx  <= n_hdr_idx;
            r_type     <= n_type;
            r_size     <= n_size;
            r_version  <= n_version;
            r_left     <= n_left;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/chsw_back.sv =====
// Back part: result queue that hands out each entry as one or two beats.
`default_nettype none

module chsw_back
    import chsw_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    output logic        o_empty,
    input  wire logic   i_pop,
    output t_out_item   o_result
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             r_sub;

    t_entry head;
    logic   pop_ok;
    logic   deq;

    assign head    = r_mem[r_rd_ptr];
    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign pop_ok  = i_pop && !o_empty;
    assign deq     = pop_ok && (r_sub || !head.two);

    always_comb begin
        o_result      = r_sub ? head.res_b : head.res_a;
        o_result.last = r_sub || !head.two;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (deq) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(deq);
            if (pop_ok) begin
                r_sub <= !deq;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/chunk_header_stream_walker_unit.sv =====
// An item's results are written into the result queue when it is taken; o_result shows the queue head.
// One item per cycle while the queue is not full; an item with two results is handed out as two beats.
// The result queue holds QUEUE_DEPTH entries of one or two beats each; full follows it.
// Reset is synchronous and active low: walk goes idle, the queue empties,
// and all configuration registers clear to zero.
`default_nettype none

module chunk_header_stream_walker_unit
    import chsw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_in_item    i_item,
    output logic             empty,
    input  wire logic        pop,
    output t_out_item        o_result,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic [31:0] r_region_size;
    logic [1:0]  r_walk_mode;
    logic [31:0] r_match_type;

    logic   accept;
    logic   q_push;
    t_entry q_entry;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_size <= '0;
            r_walk_mode   <= '0;
            r_match_type  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_REGION_SIZE: r_region_size <= i_cfg_data;
                CFG_WALK_MODE:   r_walk_mode   <= i_cfg_data[1:0];
                CFG_MATCH_TYPE:  r_match_type  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    chsw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_item),
        .i_region_size (r_region_size),
        .i_walk_mode   (r_walk_mode),
        .i_match_type  (r_match_type),
        .o_q_push      (q_push),
        .o_q_entry     (q_entry)
    );

    chsw_back #(
        .DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (q_entry),
        .o_full   (full),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

    // A beat that is not the last of its item is always a chunk record.
    a_first_of_two_is_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.last) |-> (o_result.kind == KIND_RECORD))
        else $error("non-last beat is not a chunk record");

    // Taking a non-last beat leaves its partner waiting.
    a_second_beat_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.last) |=> !empty)
        else $error("second beat missing after first beat");

    // The partner of a record is an end or an error, never another record.
    a_second_not_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.last) |=> (o_result.kind != KIND_RECORD))
        else $error("second beat of an item is a chunk record");

endmodule

`default_nettype wire
